/* rtl/core/pja_pkg.sv */
package pja_pkg;

    localparam int SUM_BITS       = 48;
    localparam int JITTER_BITS    = 32;
    localparam int FACTOR_BITS    = 16;
    localparam int FACTOR_FRAC    = 12;
    localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 16'd5325;

    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_START = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_END   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PERIOD_MIN   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PERIOD_MAX   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_FACTOR   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PERIOD,
        ST_RATIO,
        ST_ACCUM,
        ST_DIV_START,
        ST_DIVIDE,
        ST_LOAD
    } pja_state_t;

    typedef struct packed {
        logic take_input;
        logic calc_period;
        logic calc_ratio;
        logic accumulate;
        logic div_start;
        logic div_step;
        logic load_out;
    } pja_cmd_t;

    typedef struct packed {
        logic last_pulse;
        logic div_done;
    } pja_status_t;

endpackage

/* rtl/core/pja_interfaces.sv */
interface pja_pulse_if #(parameter int TIME_BITS = 32);
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] pulse_time;
    logic                 last_pulse;

    modport source (output valid, pulse_time, last_pulse, input ready);
    modport sink   (input valid, pulse_time, last_pulse, output ready);
endinterface

interface pja_result_if #(parameter int COUNT_BITS = 16);
    logic                             valid;
    logic                             ready;
    logic [pja_pkg::JITTER_BITS-1:0]  jitter_abs;
    logic                             is_defined;
    logic [COUNT_BITS-1:0]            valid_pairs;

    modport source (output valid, jitter_abs, is_defined, valid_pairs, input ready);
    modport sink   (input valid, jitter_abs, is_defined, valid_pairs, output ready);
endinterface

interface pja_cfg_if #(parameter int DATA_BITS = 32);
    logic                                valid;
    logic                                ready;
    logic [pja_pkg::CFG_INDEX_BITS-1:0]  index;
    logic [DATA_BITS-1:0]                data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/pulse_jitter_absolute_core.sv */
// Mean absolute jitter of a pulse stream. Pulse timestamps arrive on the pulse
// channel; those outside the configured window are dropped (an end not after
// the start opens the window fully). Adjacent period pairs that pass the period
// limits and the ratio limit add their absolute difference to a 48-bit sum.
// The pulse flagged last produces one result transfer: the mean difference in
// ticks with FRAC_BITS fraction bits (saturating at 32 bits), a defined flag
// and the pair count; the stream state then starts over. Each pulse passes
// through the steps accept, period, ratio multiply and accumulate in order. A
// last pulse then runs the bit-serial divider and waits for the result
// register to drain. Configuration writes are taken in any cycle but should
// only be made while the block is idle.
module pulse_jitter_absolute_core #(
    parameter int TIME_BITS   = 32,
    parameter int PERIOD_BITS = 24,
    parameter int COUNT_BITS  = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    pja_pulse_if.sink    pulse,
    pja_result_if.source result,
    pja_cfg_if.sink      cfg
);
    import pja_pkg::*;

    localparam int CFG_BITS_A = (TIME_BITS > PERIOD_BITS) ? TIME_BITS : PERIOD_BITS;
    localparam int CFG_BITS   = (CFG_BITS_A > FACTOR_BITS) ? CFG_BITS_A : FACTOR_BITS;

    pja_cmd_t    cmd;
    pja_status_t status;
    logic        cfg_we;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    pja_controller u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pulse_valid (pulse.valid),
        .pulse_ready (pulse.ready),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .status      (status),
        .cmd         (cmd)
    );

    pja_datapath #(
        .TIME_BITS   (TIME_BITS),
        .PERIOD_BITS (PERIOD_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .CFG_BITS    (CFG_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .pulse_time  (pulse.pulse_time),
        .last_pulse  (pulse.last_pulse),
        .jitter_abs  (result.jitter_abs),
        .is_defined  (result.is_defined),
        .valid_pairs (result.valid_pairs)
    );

endmodule

/* rtl/core/pja_datapath.sv */
module pja_datapath #(
    parameter int TIME_BITS   = 32,
    parameter int PERIOD_BITS = 24,
    parameter int COUNT_BITS  = 16,
    parameter int FRAC_BITS   = 8,
    parameter int CFG_BITS    = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pja_pkg::pja_cmd_t                   cmd,
    output pja_pkg::pja_status_t                status,
    input  logic                                cfg_we,
    input  logic [pja_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [CFG_BITS-1:0]                 cfg_data,
    input  logic [TIME_BITS-1:0]                pulse_time,
    input  logic                                last_pulse,
    output logic [pja_pkg::JITTER_BITS-1:0]     jitter_abs,
    output logic                                is_defined,
    output logic [COUNT_BITS-1:0]               valid_pairs
);
    import pja_pkg::*;

    localparam int WIDE_BITS     = (TIME_BITS > PERIOD_BITS) ? TIME_BITS : PERIOD_BITS;
    localparam int PROD_BITS     = FACTOR_BITS + PERIOD_BITS;
    localparam int DIVIDEND_BITS = SUM_BITS + FRAC_BITS;
    localparam int STEP_BITS     = $clog2(DIVIDEND_BITS + 1);
    localparam logic [PERIOD_BITS-1:0] PERIOD_SAT = '1;
    localparam logic [COUNT_BITS-1:0]  COUNT_SAT  = '1;

    // configuration
    logic [TIME_BITS-1:0]   window_start_reg;
    logic [TIME_BITS-1:0]   window_end_reg;
    logic [PERIOD_BITS-1:0] period_min_reg;
    logic [PERIOD_BITS-1:0] period_max_reg;
    logic [FACTOR_BITS-1:0] max_factor_reg;

    // stream state
    logic [TIME_BITS-1:0]   previous_time_reg;
    logic [PERIOD_BITS-1:0] previous_period_reg;
    logic [1:0]             points_seen_reg;
    logic [SUM_BITS-1:0]    difference_sum_reg;
    logic [COUNT_BITS-1:0]  pair_count_reg;

    // per-pulse work registers
    logic [TIME_BITS-1:0]   time_reg;
    logic                   last_reg;
    logic                   pass_reg;
    logic [PERIOD_BITS-1:0] period_reg;
    logic [PERIOD_BITS-1:0] big_reg;
    logic [PERIOD_BITS-1:0] delta_reg;
    logic [PROD_BITS-1:0]   product_reg;
    logic                   range_ok_reg;
    logic                   small_zero_reg;

    // divider
    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [COUNT_BITS-1:0]    rem_reg;
    logic [COUNT_BITS-1:0]    divisor_reg;
    logic [STEP_BITS-1:0]     step_reg;

    // result
    logic [JITTER_BITS-1:0] jitter_reg;
    logic                   defined_reg;
    logic [COUNT_BITS-1:0]  pairs_reg;

    logic                   accept_all;
    logic                   in_window;
    logic [TIME_BITS-1:0]   elapsed;
    logic [WIDE_BITS-1:0]   elapsed_wide;
    logic [PERIOD_BITS-1:0] period_calc;
    logic [PERIOD_BITS-1:0] big_calc;
    logic [PERIOD_BITS-1:0] small_calc;
    logic                   range_ok;
    logic                   checks_off;
    logic                   ratio_ok;
    logic                   pair_ok;
    logic [SUM_BITS:0]      sum_wide;
    logic [COUNT_BITS:0]    rem_shift;
    logic                   rem_fits;
    logic [JITTER_BITS-1:0] jitter_calc;

    assign accept_all = window_end_reg <= window_start_reg;
    assign in_window  = (pulse_time >= window_start_reg) && (pulse_time <= window_end_reg);

    always_comb
    begin
        elapsed = '0;
        if (points_seen_reg != 2'd0 && time_reg >= previous_time_reg)
        begin
            elapsed = time_reg - previous_time_reg;
        end
        elapsed_wide = WIDE_BITS'(elapsed);
        if (elapsed_wide > WIDE_BITS'(PERIOD_SAT))
        begin
            period_calc = PERIOD_SAT;
        end
        else
        begin
            period_calc = PERIOD_BITS'(elapsed_wide);
        end
    end

    always_comb
    begin
        if (previous_period_reg > period_reg)
        begin
            big_calc   = previous_period_reg;
            small_calc = period_reg;
        end
        else
        begin
            big_calc   = period_reg;
            small_calc = previous_period_reg;
        end
    end

    assign range_ok = (previous_period_reg >= period_min_reg) &&
                      (previous_period_reg <= period_max_reg) &&
                      (period_reg >= period_min_reg) && (period_reg <= period_max_reg);

    assign checks_off = period_min_reg == period_max_reg;
    assign ratio_ok   = (PROD_BITS'(big_reg) << FACTOR_FRAC) <= product_reg;
    assign pair_ok    = checks_off || (range_ok_reg && !small_zero_reg && ratio_ok);
    assign sum_wide   = {1'b0, difference_sum_reg} + (SUM_BITS + 1)'(delta_reg);

    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign rem_fits  = rem_shift >= {1'b0, divisor_reg};

    // quotient beyond the output range saturates
    assign jitter_calc = (|quo_reg[DIVIDEND_BITS-1:JITTER_BITS]) ? '1
                                                                  : quo_reg[JITTER_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg <= '0;
            window_end_reg   <= '0;
            period_min_reg   <= '0;
            period_max_reg   <= '0;
            max_factor_reg   <= FACTOR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_START: window_start_reg <= TIME_BITS'(cfg_data);
                CFG_WINDOW_END:   window_end_reg   <= TIME_BITS'(cfg_data);
                CFG_PERIOD_MIN:   period_min_reg   <= PERIOD_BITS'(cfg_data);
                CFG_PERIOD_MAX:   period_max_reg   <= PERIOD_BITS'(cfg_data);
                CFG_MAX_FACTOR:   max_factor_reg   <= FACTOR_BITS'(cfg_data);
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_time_reg   <= '0;
            previous_period_reg <= '0;
            points_seen_reg     <= '0;
            difference_sum_reg  <= '0;
            pair_count_reg      <= '0;
            step_reg            <= '0;
        end
        else
        begin
            if (cmd.accumulate && pass_reg)
            begin
                if (points_seen_reg != 2'd0)
                begin
                    previous_period_reg <= period_reg;
                end
                // full counter: further pairs are dropped, not summed
                if (points_seen_reg == 2'd2 && pair_count_reg != COUNT_SAT && pair_ok)
                begin
                    difference_sum_reg <= sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
                    pair_count_reg     <= pair_count_reg + 1'b1;
                end
                previous_time_reg <= time_reg;
                if (points_seen_reg != 2'd2)
                begin
                    points_seen_reg <= points_seen_reg + 2'd1;
                end
            end
            if (cmd.load_out)
            begin
                previous_time_reg   <= '0;
                previous_period_reg <= '0;
                points_seen_reg     <= '0;
                difference_sum_reg  <= '0;
                pair_count_reg      <= '0;
            end
            if (cmd.div_start)
            begin
                step_reg <= STEP_BITS'(DIVIDEND_BITS);
            end
            else if (cmd.div_step && step_reg != '0)
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_input)
        begin
            time_reg <= pulse_time;
            last_reg <= last_pulse;
            pass_reg <= accept_all || in_window;
        end
        if (cmd.calc_period)
        begin
            period_reg <= period_calc;
        end
        if (cmd.calc_ratio)
        begin
            big_reg        <= big_calc;
            delta_reg      <= big_calc - small_calc;
            product_reg    <= PROD_BITS'(max_factor_reg) * PROD_BITS'(small_calc);
            range_ok_reg   <= range_ok;
            small_zero_reg <= small_calc == '0;
        end
        if (cmd.div_start)
        begin
            quo_reg     <= DIVIDEND_BITS'(difference_sum_reg) << FRAC_BITS;
            rem_reg     <= '0;
            divisor_reg <= pair_count_reg;
        end
        else if (cmd.div_step && step_reg != '0)
        begin
            // restoring division, one quotient bit per cycle
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], rem_fits};
            rem_reg <= rem_fits ? COUNT_BITS'(rem_shift - {1'b0, divisor_reg})
                                : COUNT_BITS'(rem_shift);
        end
        if (cmd.load_out)
        begin
            defined_reg <= pair_count_reg != '0;
            jitter_reg  <= (pair_count_reg != '0) ? jitter_calc : '0;
            pairs_reg   <= pair_count_reg;
        end
    end

    assign status.last_pulse = last_reg;
    assign status.div_done   = step_reg == '0;

    assign jitter_abs  = jitter_reg;
    assign is_defined  = defined_reg;
    assign valid_pairs = pairs_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        (pair_count_reg == '0) |-> (difference_sum_reg == '0))
        else $error("difference sum nonzero with no valid pair");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != '0 && divisor_reg != '0) |-> (rem_reg < divisor_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule

/* rtl/core/pja_controller.sv */
module pja_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pulse_valid,
    output logic                  pulse_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  pja_pkg::pja_status_t  status,
    output pja_pkg::pja_cmd_t     cmd
);
    import pja_pkg::*;

    pja_state_t state_reg;
    pja_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        pulse_ready    = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                pulse_ready = 1'b1;
                if (pulse_valid)
                begin
                    cmd.take_input = 1'b1;
                    state_next     = ST_PERIOD;
                end
            end
            ST_PERIOD:
            begin
                cmd.calc_period = 1'b1;
                state_next      = ST_RATIO;
            end
            ST_RATIO:
            begin
                cmd.calc_ratio = 1'b1;
                state_next     = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accumulate = 1'b1;
                state_next     = status.last_pulse ? ST_DIV_START : ST_IDLE;
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // result register free or being emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_LOAD))
        else $error("result raised outside the load step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE && status.div_done) |=> (state_reg == ST_LOAD))
        else $error("finished division not followed by load");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
    import pja_pkg::*;

    localparam int     FRAC         = 8;
    localparam longint CYCLE_LIMIT  = 2_000_000;
    localparam int     RANDOM_ITEMS = 1550;
    localparam int     HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [JITTER_BITS-1:0] jitter_abs;
        logic                   is_defined;
        logic [15:0]            valid_pairs;
    } jitter_result_t;

    logic clk = 1'b0;
    logic rst_n;

    pja_pulse_if  #(.TIME_BITS(32))  pulse_ch ();
    pja_result_if #(.COUNT_BITS(16)) result_ch ();
    pja_cfg_if    #(.DATA_BITS(32))  cfg_ch ();

    pulse_jitter_absolute_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .pulse  (pulse_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // shadow of the configuration registers
    logic [31:0]            win_start;
    logic [31:0]            win_end;
    logic [23:0]            per_min;
    logic [23:0]            per_max;
    logic [FACTOR_BITS-1:0] ratio_limit;

    // shadow of the stream state
    logic [31:0]         prev_time;
    logic [23:0]         prev_period;
    logic [1:0]          points;
    logic [SUM_BITS-1:0] diff_sum;
    logic [15:0]         pair_cnt;

    jitter_result_t pending_jitter[$];

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_left     = 0;
    bit          hold_go       = 1'b0;
    bit          hold_used     = 1'b0;
    int          mismatches    = 0;
    int          results_seen  = 0;
    int          pulses_sent   = 0;
    int          pulses_taken  = 0;
    int          cfg_writes    = 0;
    longint      cycles        = 0;

    int unsigned phase_nominal;
    int unsigned phase_wiggle;
    logic [31:0] phase_origin;

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: errors");
            $finish;
        end
    end

    function automatic void clear_stream();
        prev_time   = '0;
        prev_period = '0;
        points      = '0;
        diff_sum    = '0;
        pair_cnt    = '0;
    endfunction

    function automatic bit pair_passes(input logic [23:0] a, input logic [23:0] b);
        logic [23:0] p_hi;
        logic [23:0] p_lo;
        if (per_min == per_max)
            return 1'b1;
        if (a < per_min || a > per_max || b < per_min || b > per_max)
            return 1'b0;
        p_hi = (a > b) ? a : b;
        p_lo = (a > b) ? b : a;
        if (p_lo == 0)
            return 1'b0;
        return (64'(p_hi) << FACTOR_FRAC) <= (64'(ratio_limit) * 64'(p_lo));
    endfunction

    // 24.8 mean of the summed differences, saturating at 32 bits
    function automatic logic [31:0] mean_difference();
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] val;
        if (pair_cnt == 0)
            return '0;
        quo = 64'(diff_sum) / 64'(pair_cnt);
        rem = 64'(diff_sum) % 64'(pair_cnt);
        if (quo > (64'hFFFF_FFFF >> FRAC))
            return '1;
        val = (quo << FRAC) + ((rem << FRAC) / 64'(pair_cnt));
        return (val > 64'hFFFF_FFFF) ? '1 : val[31:0];
    endfunction

    function automatic void track_pulse(input logic [31:0] t, input logic last);
        logic [31:0]       gap;
        logic [23:0]       period;
        logic [23:0]       d;
        logic [SUM_BITS:0] sum_next;
        jitter_result_t    res;
        if (win_end <= win_start || (t >= win_start && t <= win_end))
        begin
            pulses_taken++;
            if (points != 0)
            begin
                gap    = (t >= prev_time) ? t - prev_time : '0;
                period = (gap > 32'h00FF_FFFF) ? 24'hFF_FFFF : gap[23:0];
                // a saturated pair counter freezes the sum as well
                if (points == 2 && pair_cnt != 16'hFFFF && pair_passes(prev_period, period))
                begin
                    d = (prev_period > period) ? prev_period - period : period - prev_period;
                    sum_next = {1'b0, diff_sum} + {25'd0, d};
                    diff_sum = sum_next[SUM_BITS] ? '1 : sum_next[SUM_BITS-1:0];
                    pair_cnt++;
                end
                prev_period = period;
            end
            prev_time = t;
            if (points != 2)
                points++;
        end
        if (last)
        begin
            res.jitter_abs  = mean_difference();
            res.is_defined  = (pair_cnt != 0);
            res.valid_pairs = pair_cnt;
            pending_jitter.push_back(res);
            clear_stream();
        end
    endfunction

    function automatic void note_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("tb: mismatch on %s at result %0d: expected %0h, got %0h",
                     field, results_seen, want, got);
    endfunction

    always @(posedge clk)
    begin : check_result
        jitter_result_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            results_seen++;
            if (pending_jitter.size() == 0)
                note_mismatch("unexpected result", '0, result_ch.jitter_abs);
            else
            begin
                want = pending_jitter.pop_front();
                if (result_ch.jitter_abs !== want.jitter_abs)
                    note_mismatch("jitter_abs", want.jitter_abs, result_ch.jitter_abs);
                if (result_ch.is_defined !== want.is_defined)
                    note_mismatch("is_defined", 32'(want.is_defined), 32'(result_ch.is_defined));
                if (result_ch.valid_pairs !== want.valid_pairs)
                    note_mismatch("valid_pairs", 32'(want.valid_pairs),
                                  32'(result_ch.valid_pairs));
            end
        end
    end

    // result ready; a hold-off request blocks it until hold_left counts down to zero
    always @(posedge clk)
    begin
        if (hold_go && !hold_used)
        begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_pulse(input logic [31:0] t, input logic last);
        int unsigned gap_cycles;
        gap_cycles = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap_cycles++;
        if (gap_cycles != 0)
        begin
            pulse_ch.valid <= 1'b0;
            repeat (gap_cycles) @(posedge clk);
        end
        pulse_ch.valid      <= 1'b1;
        pulse_ch.pulse_time <= t;
        pulse_ch.last_pulse <= last;
        @(posedge clk);
        while (pulse_ch.ready !== 1'b1)
            @(posedge clk);
        pulses_sent++;
        track_pulse(t, last);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        case (idx)
            CFG_WINDOW_START: win_start   = value;
            CFG_WINDOW_END:   win_end     = value;
            CFG_PERIOD_MIN:   per_min     = value[23:0];
            CFG_PERIOD_MAX:   per_max     = value[23:0];
            CFG_MAX_FACTOR:   ratio_limit = value[FACTOR_BITS-1:0];
            default: ;
        endcase
        cfg_writes++;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every expected result plus the tail of a pulse still in flight
    task automatic drain();
        pulse_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_jitter.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic test_reset_config();
        // window open, limits equal: every pair counts; last period saturates
        send_pulse(32'd0, 1'b0);
        send_pulse(32'd100, 1'b0);
        send_pulse(32'd250, 1'b0);
        send_pulse(32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_window();
        drain();
        write_reg(CFG_WINDOW_START, 32'd1000);
        write_reg(CFG_WINDOW_END, 32'd2000);
        send_pulse(32'd500, 1'b0);
        send_pulse(32'd1000, 1'b0);
        send_pulse(32'd1100, 1'b0);
        send_pulse(32'd2000, 1'b0);
        send_pulse(32'd2600, 1'b1);   // last pulse outside the window
        drain();
        write_reg(CFG_WINDOW_START, 32'hFFFF_FFFF);
        write_reg(CFG_WINDOW_END, 32'd0);
        send_pulse(32'd5000, 1'b0);
        send_pulse(32'd5100, 1'b0);
        send_pulse(32'd5050, 1'b0);   // goes backwards: zero period
        send_pulse(32'd5200, 1'b1);
    endtask

    task automatic test_period_checks();
        drain();
        write_reg(CFG_PERIOD_MIN, 32'h00FF_FFFF);
        write_reg(CFG_PERIOD_MAX, 32'd0);
        send_pulse(32'd10, 1'b0);
        send_pulse(32'd20, 1'b0);
        send_pulse(32'd30, 1'b1);
        drain();
        write_reg(CFG_PERIOD_MIN, 32'd0);
        write_reg(CFG_PERIOD_MAX, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_FACTOR, 32'h0000_FFFF);
        send_pulse(32'd0, 1'b0);
        send_pulse(32'd10, 1'b0);
        send_pulse(32'd10, 1'b0);
        send_pulse(32'd20, 1'b0);
        send_pulse(32'd30, 1'b1);
        drain();
        write_reg(CFG_MAX_FACTOR, 32'(FACTOR_RESET));
        write_reg(CFG_PERIOD_MAX, 32'd1000);
        // 130/100 sits just inside the reset ratio, 131/100 just outside
        send_pulse(32'd0, 1'b0);
        send_pulse(32'd100, 1'b0);
        send_pulse(32'd230, 1'b0);
        send_pulse(32'd361, 1'b0);
        send_pulse(32'd461, 1'b1);
    endtask

    task automatic test_output_stall();
        int          saved_pct;
        logic [31:0] t;
        drain();
        write_reg(CFG_WINDOW_START, 32'd0);
        write_reg(CFG_WINDOW_END, 32'd0);
        write_reg(CFG_PERIOD_MIN, 32'd0);
        write_reg(CFG_PERIOD_MAX, 32'd0);
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        hold_go       = 1'b1;
        repeat (6)
        begin
            t = $urandom;
            for (int i = 0; i < 4; i++)
            begin
                t = t + $urandom_range(1, 500);
                send_pulse(t, i == 3);
            end
        end
        send_idle_pct = saved_pct;
    endtask

    task automatic pick_random_setup();
        logic [31:0] w_start;
        logic [31:0] w_end;
        logic [23:0] p_min;
        logic [23:0] p_max;
        logic [15:0] factor;
        logic [7:0]  junk;
        int unsigned pick;
        case ($urandom_range(3))
            0:       phase_nominal = $urandom_range(1, 20);
            1:       phase_nominal = $urandom_range(21, 4000);
            2:       phase_nominal = $urandom_range(4001, 8_000_000);
            default: phase_nominal = $urandom_range(1, 200);
        endcase
        phase_wiggle = phase_nominal >> $urandom_range(2, 6);
        phase_origin = ($urandom_range(7) == 0) ? 32'd0 : $urandom_range(32'hF000_0000);

        pick = $urandom_range(9);
        if (pick <= 3)
        begin
            w_start = $urandom;
            w_end   = $urandom_range(w_start);
        end
        else if (pick <= 8)
        begin
            w_start = phase_origin + phase_nominal * $urandom_range(4);
            w_end   = w_start + phase_nominal * $urandom_range(2, 20);
        end
        else
        begin
            w_start = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
            w_end   = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
        end

        pick = $urandom_range(9);
        if (pick <= 2)
        begin
            p_min = 24'($urandom);
            p_max = p_min;
        end
        else if (pick <= 7)
        begin
            p_min = 24'(phase_nominal - 2 * phase_wiggle);
            p_max = 24'(phase_nominal + $urandom_range(2 * phase_wiggle));
        end
        else if (pick == 8)
        begin
            p_max = 24'($urandom_range(24'hFF_FFFE));
            p_min = 24'(p_max + $urandom_range(1, 24'hFF_FFFF - p_max));
        end
        else
        begin
            p_min = '0;
            p_max = '1;
        end

        pick = $urandom_range(9);
        if (pick <= 6)
            factor = 16'($urandom_range(4096, 6000));
        else if (pick == 7)
            factor = '0;
        else if (pick == 8)
            factor = '1;
        else
            factor = 16'($urandom);

        junk = 8'($urandom);
        write_reg(CFG_WINDOW_START, w_start);
        write_reg(CFG_WINDOW_END, w_end);
        write_reg(CFG_PERIOD_MIN, {junk, p_min});
        junk = 8'($urandom);
        write_reg(CFG_PERIOD_MAX, {junk, p_max});
        write_reg(CFG_MAX_FACTOR, {junk, junk, factor});
    endtask

    // mostly steady periods around the nominal, with rare glitches
    task automatic send_stream(input int unsigned len, input logic [31:0] start_t);
        logic [31:0] t;
        int unsigned pick;
        t = start_t;
        for (int unsigned i = 0; i < len; i++)
        begin
            pick = $urandom_range(99);
            if (i != 0)
            begin
                if (pick < 4)
                    t = t - $urandom_range(phase_nominal);
                else if (pick < 7)
                    t = t + 32'h0100_0000 + $urandom_range(32'h00FF_FFFF);
                else if (pick >= 9)
                    t = t + phase_nominal + phase_wiggle - $urandom_range(2 * phase_wiggle);
            end
            send_pulse(t, i == len - 1);
        end
    endtask

    task automatic send_noise_stream();
        int unsigned len;
        len = $urandom_range(1, 6);
        for (int unsigned i = 0; i < len; i++)
            send_pulse($urandom, i == len - 1);
    endtask

    task automatic run_random(input int n);
        int start_sent;
        int unsigned len;
        start_sent = pulses_sent;
        while (pulses_sent - start_sent < n)
        begin
            drain();
            pick_random_setup();
            repeat ($urandom_range(2, 6))
            begin
                if ($urandom_range(9) == 0)
                    send_noise_stream();
                else
                begin
                    len = ($urandom_range(19) == 0) ? $urandom_range(1, 2)
                                                     : $urandom_range(3, 24);
                    send_stream(len, phase_origin + phase_nominal * $urandom_range(3));
                end
            end
        end
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        pulse_ch.valid      <= 1'b0;
        pulse_ch.pulse_time <= '0;
        pulse_ch.last_pulse <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_WINDOW_START;
        cfg_ch.data         <= '0;
        win_start   = '0;
        win_end     = '0;
        per_min     = '0;
        per_max     = '0;
        ratio_limit = FACTOR_RESET;
        clear_stream();
        send_idle_pct = 34;
        recv_idle_pct = 79;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_window();
        test_period_checks();
        test_output_stall();
        run_random(RANDOM_ITEMS / 3);
        send_idle_pct = 79;
        recv_idle_pct = 34;
        run_random(RANDOM_ITEMS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RANDOM_ITEMS / 3);

        drain();
        repeat (80) @(posedge clk);
        $display("tb: %0d pulses offered, %0d inside the window, %0d results checked",
                 pulses_sent, pulses_taken, results_seen);
        $display("tb: %0d register writes across window, limit and ratio settings, %0d mismatches",
                 cfg_writes, mismatches);
        if (mismatches == 0 && pending_jitter.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/pja_pkg.sv
rtl/core/pja_interfaces.sv
rtl/core/pja_datapath.sv
rtl/core/pja_controller.sv
rtl/core/pulse_jitter_absolute_core.sv
tb/sv/tb.sv
